// File: design/pse_pkg.sv
// Shared types, constants and character folding functions for the printable
// string extractor. Depends on nothing; printable_string_extractor uses it.
package pse_pkg;

  // Pending modes carried from one byte to the next.
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_ZERO = 2'd1;
  localparam logic [1:0] MODE_LEAD = 2'd2;

  localparam logic [7:0] LEAD_BYTE      = 8'hC3;
  localparam logic [6:0] CHAR_A         = 7'h61;
  localparam logic [6:0] CHAR_NEWLINE   = 7'd10;
  localparam logic [6:0] CHAR_FAIL      = 7'd0;
  localparam logic [3:0] MIN_LENGTH_RST = 4'd4;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_OP      = 5'b00010,
    ST_DRAIN   = 5'b00100,
    ST_NEWLINE = 5'b01000,
    ST_FIN     = 5'b10000
  } state_t;

  // Fold for the upper Latin-1 half; zero when the code is not a known letter.
  function automatic logic [6:0] fold_latin(input logic [7:0] c);
    logic [7:0] u;
    u = c & 8'hDF;
    if (u >= 8'd192 && u <= 8'd197) return 7'h61;
    if (u == 8'd199) return 7'h63;
    if (u >= 8'd200 && u <= 8'd203) return 7'h65;
    if (u >= 8'd204 && u <= 8'd207) return 7'h69;
    if (u == 8'd209) return 7'h6E;
    if (u >= 8'd210 && u <= 8'd214) return 7'h6F;
    if (u >= 8'd217 && u <= 8'd220) return 7'h75;
    return CHAR_FAIL;
  endfunction

  // Fold for a single byte; zero when the byte is not printable.
  function automatic logic [6:0] fold_byte(input logic [7:0] c);
    if (c == 8'd9) return 7'd9;
    if (c >= 8'd65 && c <= 8'd90) return c[6:0] + 7'd32;
    if (c >= 8'd32 && c <= 8'd126) return c[6:0];
    if (c >= 8'd192) return fold_latin(c);
    return CHAR_FAIL;
  endfunction

  // Fold for the byte after a lead byte; zero when it is not a known letter.
  function automatic logic [6:0] fold_follower(input logic [7:0] n);
    if (n >= 8'd128 && n <= 8'd191) return fold_latin(n + 8'd64);
    return CHAR_FAIL;
  endfunction

endpackage

// File: design/printable_string_extractor.sv
// Printable string extractor top level: byte sequencer, candidate memory and
// output staging. Depends on pse_pkg for codes and folding functions.
//
// Usage: raw bytes enter on the byte channel (data_byte, end_of_stream) under
// byte_valid/byte_stall; folded characters leave on the char channel under
// char_valid/char_stall. A request is taken at a clock edge with valid high
// and stall low. Characters are held in a small candidate memory until
// min_length have collected, then replayed with string_first on the first
// one and start_offset on each; a string_end item (newline) closes a string.
// last_of_run marks the final result caused by one input byte.
// A byte holds the sequencer in ST_OP for each character it yields (a
// non-printable one included), in ST_DRAIN for each character replayed from
// the candidate memory (one synchronous read a cycle while the output does
// not stall), in ST_NEWLINE for a newline that closes a string at stream
// end, and in ST_FIN; byte_stall is high in every state but ST_IDLE.
// A result waits in a staging register until the byte's next result or the
// end of its work moves it on, as only then is last_of_run known. A char
// stall holds the sequencer once both registers fill.
// rst (synchronous) empties the pipeline, clears the stream state and sets
// min_length to 4. The candidate memory needs no clearing pass.
// min_length is written through cfg_we/cfg_data; values of zero or above
// MAX_MIN_LENGTH are ignored.
module printable_string_extractor #(
  parameter int MAX_MIN_LENGTH = 9,
  parameter int OFFSET_BITS    = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [3:0]             cfg_data,
  input  logic                   byte_valid,
  output logic                   byte_stall,
  input  logic [7:0]             data_byte,
  input  logic                   end_of_stream,
  output logic                   char_valid,
  input  logic                   char_stall,
  output logic [6:0]             text_char,
  output logic                   string_first,
  output logic [OFFSET_BITS-1:0] start_offset,
  output logic                   string_end,
  output logic                   last_of_run
);

  localparam int CNT_W = $clog2(MAX_MIN_LENGTH + 1);
  localparam int IDX_W = (MAX_MIN_LENGTH > 1) ? $clog2(MAX_MIN_LENGTH) : 1;
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

  pse_pkg::state_t state;

  logic [3:0]             min_length;
  logic [1:0]             pending;
  logic [CNT_W-1:0]       count;
  logic                   in_string;
  logic [OFFSET_BITS-1:0] byte_position;
  logic [OFFSET_BITS-1:0] cstart;

  // Per-byte work list.
  logic [6:0]             op_char0;
  logic [6:0]             op_char1;
  logic [1:0]             op_n;
  logic [1:0]             op_i;
  logic                   end_flag;
  logic [OFFSET_BITS-1:0] item_p1;

  // Candidate memory and replay counters.
  logic [6:0]       mem [MAX_MIN_LENGTH];
  logic [6:0]       mem_q;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] raddr;
  logic [CNT_W-1:0] drain_len;
  logic             mem_we;
  logic [IDX_W-1:0] waddr;

  // Staging register ahead of the output register.
  logic                   hold_valid;
  logic [6:0]             hold_char;
  logic                   hold_first;
  logic                   hold_end;
  logic [OFFSET_BITS-1:0] hold_off;

  // Accept-time decode.
  logic [6:0]             op_char0_next;
  logic [6:0]             op_char1_next;
  logic [1:0]             op_n_next;
  logic [1:0]             pending_next;
  logic [OFFSET_BITS-1:0] p1;
  logic [6:0]             fol;
  logic [6:0]             fb;

  logic             char_free;
  logic             adv;
  logic             op_done;
  logic [6:0]       cur_char;
  logic [CNT_W-1:0] count_new;
  logic             cand_full;
  logic             drain_last;
  logic             cfg_ok;

  logic                   emit_en;
  logic [6:0]             emit_char;
  logic                   emit_first;
  logic                   emit_end;
  logic                   fin_move;
  logic                   move_hold;

  assign byte_stall = (state != pse_pkg::ST_IDLE);
  assign char_free  = !char_valid || !char_stall;
  assign adv        = !hold_valid || char_free;
  assign p1         = byte_position + OFFSET_BITS'(1);
  assign fol        = pse_pkg::fold_follower(data_byte);
  assign fb         = pse_pkg::fold_byte(data_byte);
  assign cfg_ok     = (cfg_data != 4'd0) &&
                      (CMP_W'(cfg_data) <= CMP_W'(MAX_MIN_LENGTH));

  // A byte yields at most two characters: a flushed lone lead byte and the
  // byte itself, or the byte and a lead byte flushed at stream end.
  always_comb begin
    logic consumed;
    op_char0_next = pse_pkg::CHAR_FAIL;
    op_char1_next = pse_pkg::CHAR_FAIL;
    op_n_next     = 2'd0;
    pending_next  = pse_pkg::MODE_NONE;
    consumed      = 1'b0;
    if (pending == pse_pkg::MODE_LEAD) begin
      op_n_next = 2'd1;
      if (fol != pse_pkg::CHAR_FAIL) begin
        op_char0_next = fol;
        consumed      = 1'b1;
      end else begin
        op_char0_next = pse_pkg::CHAR_A;
      end
    end
    if (!consumed) begin
      priority if (pending == pse_pkg::MODE_ZERO) begin
        op_char0_next = fb;
        op_n_next     = 2'd1;
      end else if (data_byte == 8'd0) begin
        pending_next = pse_pkg::MODE_ZERO;
      end else if (data_byte == pse_pkg::LEAD_BYTE) begin
        pending_next = pse_pkg::MODE_LEAD;
      end else begin
        if (op_n_next == 2'd0) begin
          op_char0_next = fb;
        end else begin
          op_char1_next = fb;
        end
        op_n_next = op_n_next + 2'd1;
      end
    end
    if (end_of_stream) begin
      if (pending_next == pse_pkg::MODE_LEAD) begin
        if (op_n_next == 2'd0) begin
          op_char0_next = pse_pkg::CHAR_A;
        end else begin
          op_char1_next = pse_pkg::CHAR_A;
        end
        op_n_next = op_n_next + 2'd1;
      end
      pending_next = pse_pkg::MODE_NONE;
    end
  end

  assign op_done   = (op_i == op_n);
  assign cur_char  = op_i[0] ? op_char1 : op_char0;
  assign count_new = count + CNT_W'(1);
  assign cand_full = (CMP_W'(count_new) >= CMP_W'(min_length)) ||
                     (count_new >= CNT_W'(MAX_MIN_LENGTH));
  assign drain_last = ((CNT_W'(rd_idx) + CNT_W'(1)) == drain_len);

  assign mem_we = (state == pse_pkg::ST_OP) && adv && !op_done &&
                  (cur_char != pse_pkg::CHAR_FAIL) && !in_string;
  assign waddr  = count[IDX_W-1:0];

  // The read address runs one step ahead so replay yields one entry a cycle while the output does not stall.
  always_comb begin
    raddr = '0;
    if (state == pse_pkg::ST_DRAIN) begin
      if (!adv) begin
        raddr = rd_idx;
      end else if (!drain_last) begin
        raddr = rd_idx + IDX_W'(1);
      end
    end
  end

  always_comb begin
    emit_en    = 1'b0;
    emit_char  = cur_char;
    emit_first = 1'b0;
    emit_end   = 1'b0;
    unique case (state)
      pse_pkg::ST_OP: begin
        if (adv && !op_done) begin
          if (cur_char == pse_pkg::CHAR_FAIL) begin
            emit_en   = in_string;
            emit_char = pse_pkg::CHAR_NEWLINE;
            emit_end  = 1'b1;
          end else begin
            emit_en = in_string;
          end
        end
      end
      pse_pkg::ST_DRAIN: begin
        emit_en    = adv;
        emit_char  = mem_q;
        emit_first = (rd_idx == '0);
      end
      pse_pkg::ST_NEWLINE: begin
        emit_en   = adv;
        emit_char = pse_pkg::CHAR_NEWLINE;
        emit_end  = 1'b1;
      end
      default: begin
        emit_en = 1'b0;
      end
    endcase
  end

  assign fin_move  = (state == pse_pkg::ST_FIN) && hold_valid && char_free;
  assign move_hold = (emit_en && hold_valid) || fin_move;

  // Candidate memory; a read of the entry written in the same cycle forwards.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= cur_char;
    end
    if (mem_we && (waddr == raddr)) begin
      mem_q <= cur_char;
    end else begin
      mem_q <= mem[raddr];
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk) begin
    if (move_hold) begin
      text_char    <= hold_char;
      string_first <= hold_first;
      string_end   <= hold_end;
      start_offset <= hold_off;
      last_of_run  <= fin_move;
    end
    if (emit_en) begin
      hold_char  <= emit_char;
      hold_first <= emit_first;
      hold_end   <= emit_end;
      hold_off   <= cstart;
    end
    if (state == pse_pkg::ST_IDLE && byte_valid) begin
      op_char0 <= op_char0_next;
      op_char1 <= op_char1_next;
      op_n     <= op_n_next;
      end_flag <= end_of_stream;
      item_p1  <= p1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= pse_pkg::ST_IDLE;
      min_length    <= pse_pkg::MIN_LENGTH_RST;
      pending       <= pse_pkg::MODE_NONE;
      count         <= '0;
      in_string     <= 1'b0;
      byte_position <= '0;
      cstart        <= '0;
      op_i          <= '0;
      rd_idx        <= '0;
      drain_len     <= '0;
      hold_valid    <= 1'b0;
      char_valid    <= 1'b0;
    end else begin
      if (cfg_we && cfg_ok) begin
        min_length <= cfg_data;
      end
      if (move_hold) begin
        char_valid <= 1'b1;
      end else if (char_valid && !char_stall) begin
        char_valid <= 1'b0;
      end
      if (emit_en) begin
        hold_valid <= 1'b1;
      end else if (fin_move) begin
        hold_valid <= 1'b0;
      end
      unique case (state)
        pse_pkg::ST_IDLE: begin
          if (byte_valid) begin
            pending       <= pending_next;
            byte_position <= end_of_stream ? '0 : p1;
            op_i          <= '0;
            state         <= pse_pkg::ST_OP;
          end
        end
        pse_pkg::ST_OP: begin
          if (adv) begin
            if (op_done) begin
              state <= (end_flag && in_string) ? pse_pkg::ST_NEWLINE : pse_pkg::ST_FIN;
            end else begin
              op_i <= op_i + 2'd1;
              if (cur_char == pse_pkg::CHAR_FAIL) begin
                // The next candidate starts just after the failing byte.
                in_string <= 1'b0;
                count     <= '0;
                cstart    <= item_p1;
              end else if (!in_string) begin
                if (cand_full) begin
                  drain_len <= count_new;
                  count     <= '0;
                  in_string <= 1'b1;
                  rd_idx    <= '0;
                  state     <= pse_pkg::ST_DRAIN;
                end else begin
                  count <= count_new;
                end
              end
            end
          end
        end
        pse_pkg::ST_DRAIN: begin
          if (adv) begin
            if (drain_last) begin
              state <= pse_pkg::ST_OP;
            end else begin
              rd_idx <= rd_idx + IDX_W'(1);
            end
          end
        end
        pse_pkg::ST_NEWLINE: begin
          if (adv) begin
            state <= pse_pkg::ST_FIN;
          end
        end
        pse_pkg::ST_FIN: begin
          if (!hold_valid || char_free) begin
            if (end_flag) begin
              count     <= '0;
              in_string <= 1'b0;
              cstart    <= '0;
            end
            state <= pse_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= pse_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule
